FILE: hdl/urm_pkg.sv
package urm_pkg;

  // history and median
  localparam int HIST_DEPTH = 8;
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int MED_LO     = (HIST_DEPTH - 1) / 2;
  localparam int MED_HI     = (MED_LO + 1 < HIST_DEPTH) ? MED_LO + 1 : MED_LO;

  // field and register widths
  localparam int INTERVAL_W = 24;
  localparam int SPEED_W    = 10;
  localparam int TIMEOUT_W  = 16;
  localparam int DIST_W     = 16;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 2;

  // distance = speed * ticks / 2000, with 2000 = 16 * 125
  localparam int PROD_W     = SPEED_W + TIMEOUT_W;
  localparam int PRE_SHIFT  = 4;
  localparam int PRE_W      = PROD_W - PRE_SHIFT;
  // ceil(2^29 / 125), exact for every 22-bit dividend
  localparam int RCP_SHIFT  = 29;
  localparam int RCP_W      = 23;
  localparam logic [RCP_W-1:0] RCP_125 = RCP_W'(4294968);
  localparam int RCP_PROD_W = PRE_W + RCP_W;

  // trigger pulse phases, in ticks
  localparam int TRIG_LOW_TICKS  = 4;
  localparam int TRIG_HIGH_TICKS = 10;

  // register reset values
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(60000);
  localparam logic [SPEED_W-1:0]    SPEED_RST    = SPEED_W'(343);
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = TIMEOUT_W'(23323);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_ECHO,
    PH_MEASURE
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_PUSH,
    BK_LOAD,
    BK_SORT,
    BK_MED,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic                 trigger;
    logic                 done;
    logic [TIMEOUT_W-1:0] echo_count;
    logic                 timed_out;
    logic                 busy;
  } tick_word_t;

endpackage

FILE: hdl/urm_front.sv
module urm_front
  import urm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_echo_level,
  input  logic [INTERVAL_W-1:0] interval_i,
  input  logic [TIMEOUT_W-1:0]  timeout_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output tick_word_t            q_word_o
);

  localparam logic [INTERVAL_W-1:0] SINCE_MAX = '1;

  phase_t                phase_r, phase_nxt;
  logic [INTERVAL_W-1:0] since_r, since_nxt;
  logic [TIMEOUT_W-1:0]  wait_r, wait_nxt;
  logic [TIMEOUT_W-1:0]  echo_cnt_r, echo_cnt_nxt;
  logic                  trig_r, trig_nxt;
  logic                  accept;
  logic                  started;
  logic                  done;
  logic                  tmo;

  assign in_stall = q_full_i;
  assign accept   = in_valid && !q_full_i;

  always_comb begin
    phase_nxt    = phase_r;
    since_nxt    = since_r;
    wait_nxt     = wait_r;
    echo_cnt_nxt = echo_cnt_r;
    trig_nxt     = trig_r;
    started      = 1'b0;
    done         = 1'b0;
    tmo          = 1'b0;
    unique case (phase_r)
      PH_TRIG_LOW: begin
        if (wait_r >= TIMEOUT_W'(TRIG_LOW_TICKS)) begin
          trig_nxt  = 1'b1;
          wait_nxt  = '0;
          phase_nxt = PH_TRIG_HIGH;
        end else begin
          wait_nxt = wait_r + 1'b1;
        end
      end
      PH_TRIG_HIGH: begin
        if (wait_r >= TIMEOUT_W'(TRIG_HIGH_TICKS)) begin
          trig_nxt  = 1'b0;
          wait_nxt  = '0;
          phase_nxt = PH_WAIT_ECHO;
        end else begin
          wait_nxt = wait_r + 1'b1;
        end
      end
      PH_WAIT_ECHO: begin
        if (wait_r >= timeout_i) begin
          tmo       = 1'b1;
          phase_nxt = PH_IDLE;
        end else if (in_echo_level) begin
          echo_cnt_nxt = '0;
          wait_nxt     = '0;
          phase_nxt    = PH_MEASURE;
        end else begin
          wait_nxt = wait_r + 1'b1;
        end
      end
      PH_MEASURE: begin
        if (echo_cnt_r >= timeout_i) begin
          tmo       = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          echo_cnt_nxt = echo_cnt_r + 1'b1;
          if (!in_echo_level) begin
            done      = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (since_r >= interval_i) begin
          trig_nxt  = 1'b0;
          since_nxt = '0;
          wait_nxt  = '0;
          phase_nxt = PH_TRIG_LOW;
          started   = 1'b1;
        end
      end
    endcase
    if (!started && since_r != SINCE_MAX) begin
      since_nxt = since_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      since_r    <= '0;
      wait_r     <= '0;
      echo_cnt_r <= '0;
      trig_r     <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      since_r    <= since_nxt;
      wait_r     <= wait_nxt;
      echo_cnt_r <= echo_cnt_nxt;
      trig_r     <= trig_nxt;
    end
  end

  assign q_push_o            = accept;
  assign q_word_o.trigger    = trig_nxt;
  assign q_word_o.done       = done;
  assign q_word_o.echo_count = echo_cnt_nxt;
  assign q_word_o.timed_out  = tmo;
  assign q_word_o.busy       = (phase_nxt != PH_IDLE);

endmodule

FILE: hdl/urm_queue.sv
module urm_queue
  import urm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_i,
  input  tick_word_t word_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output tick_word_t word_o
);

  tick_word_t           mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;

  assign full_o  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty_o = (cnt_r == '0);
  assign word_o  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem[wr_ptr_r] <= word_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/urm_back.sv
module urm_back
  import urm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SPEED_W-1:0] speed_i,
  input  logic               q_empty_i,
  input  tick_word_t         q_word_i,
  output logic               q_pop_o,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_trigger_level,
  output logic               out_new_reading,
  output logic [DIST_W-1:0]  out_distance_mm,
  output logic [DIST_W-1:0]  out_median_mm,
  output logic               out_timed_out,
  output logic               out_busy_res
);

  back_state_t           state_r, state_nxt;
  tick_word_t            word_r;
  logic [PROD_W-1:0]     prod_r;
  logic [RCP_PROD_W-1:0] rcp_prod;
  logic [DIST_W-1:0]     dist_r;
  logic [DIST_W-1:0]     hist_r [HIST_DEPTH];
  logic [CNT_W-1:0]      hist_cnt_r;
  logic [DIST_W-1:0]     sort_r [HIST_DEPTH];
  logic [DIST_W-1:0]     sort_nxt [HIST_DEPTH];
  logic [DIST_W-1:0]     load_val [HIST_DEPTH];
  logic [CNT_W-1:0]      pass_r;
  logic [DIST_W-1:0]     last_dist_r;
  logic [DIST_W-1:0]     median_r;
  logic                  out_valid_r;
  logic                  out_load;
  logic [CNT_W:0]        lo_pad;
  logic [CNT_W:0]        lo_end;
  logic [DIST_W:0]       mid_sum;
  logic [DIST_W-1:0]     median_val;

  // divide by 16 with a shift, then by 125 with a reciprocal multiply
  // the quotient of a 26-bit product stays below 2^16, so it never saturates
  assign rcp_prod = RCP_PROD_W'(prod_r[PROD_W-1:PRE_SHIFT]) * RCP_PROD_W'(RCP_125);

  // pad empty slots with zeros and ones so the middle always sits at a fixed index
  always_comb begin
    if (hist_cnt_r[0]) begin
      lo_pad = (CNT_W+1)'(MED_LO) - (CNT_W+1)'(hist_cnt_r >> 1);
    end else begin
      lo_pad = (CNT_W+1)'(MED_LO + 1) - (CNT_W+1)'(hist_cnt_r >> 1);
    end
    lo_end = (CNT_W+1)'(hist_cnt_r) + lo_pad;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      if ((CNT_W+1)'(i) < (CNT_W+1)'(hist_cnt_r)) begin
        load_val[i] = hist_r[i];
      end else if ((CNT_W+1)'(i) < lo_end) begin
        load_val[i] = '0;
      end else begin
        load_val[i] = '1;
      end
    end
  end

  // one odd-even transposition pass
  always_comb begin
    logic odd_j;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      sort_nxt[i] = sort_r[i];
    end
    for (int j = 0; j + 1 < HIST_DEPTH; j++) begin
      odd_j = 1'(j);
      if (odd_j == pass_r[0] && sort_r[j] > sort_r[j+1]) begin
        sort_nxt[j]   = sort_r[j+1];
        sort_nxt[j+1] = sort_r[j];
      end
    end
  end

  assign mid_sum    = {1'b0, sort_r[MED_LO]} + {1'b0, sort_r[MED_HI]};
  assign median_val = hist_cnt_r[0] ? sort_r[MED_LO] : mid_sum[DIST_W:1];

  always_comb begin
    state_nxt = state_r;
    q_pop_o   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          state_nxt = q_word_i.done ? BK_MUL : BK_EMIT;
        end
      end
      BK_MUL:  state_nxt = BK_DIV;
      BK_DIV:  state_nxt = BK_PUSH;
      BK_PUSH: state_nxt = BK_LOAD;
      BK_LOAD: state_nxt = BK_SORT;
      BK_SORT: begin
        if (pass_r == CNT_W'(HIST_DEPTH - 1)) begin
          state_nxt = BK_MED;
        end
      end
      BK_MED:  state_nxt = BK_EMIT;
      BK_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      hist_cnt_r  <= '0;
      last_dist_r <= '0;
      median_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_PUSH) begin
        last_dist_r <= dist_r;
        if (hist_cnt_r != CNT_W'(HIST_DEPTH)) begin
          hist_cnt_r <= hist_cnt_r + 1'b1;
        end
      end
      if (state_r == BK_MED) begin
        median_r <= median_val;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) begin
      word_r <= q_word_i;
    end
    unique case (state_r)
      BK_MUL: begin
        prod_r <= PROD_W'(speed_i) * PROD_W'(word_r.echo_count);
      end
      BK_DIV: begin
        dist_r <= rcp_prod[RCP_PROD_W-1:RCP_SHIFT];
      end
      BK_PUSH: begin
        hist_r[0] <= dist_r;
        for (int i = 1; i < HIST_DEPTH; i++) begin
          hist_r[i] <= hist_r[i-1];
        end
      end
      BK_LOAD: begin
        sort_r <= load_val;
        pass_r <= '0;
      end
      BK_SORT: begin
        sort_r <= sort_nxt;
        pass_r <= pass_r + 1'b1;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_trigger_level <= word_r.trigger;
      out_new_reading   <= word_r.done;
      out_distance_mm   <= last_dist_r;
      out_median_mm     <= median_r;
      out_timed_out     <= word_r.timed_out;
      out_busy_res      <= word_r.busy;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/ultrasonic_ranging_median_core.sv
// channel | direction | ports
// --------+-----------+-----------------------------------------------------------
// in      | input     | in_valid, in_stall, in_echo_level
// out     | output    | out_valid, out_stall, out_trigger_level, out_new_reading,
//         |           | out_distance_mm, out_median_mm, out_timed_out, out_busy_res
// cfg     | input     | cfg_we, cfg_index, cfg_data
//
// a tick word without a finished reading goes from the queue straight to the output register
// a finished reading passes through multiply, reciprocal divide by 2000,
// history shift, sort load, 8 odd-even passes, median, then the output register
// the front end runs the phase machine in the accept cycle; a 2-word queue decouples it
// synchronous active-low reset; no clearing pass, history entries are never read unwritten
// out_stall holds the output register, and in_stall rises when the queue is full
module ultrasonic_ranging_median_core
  import urm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_echo_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_trigger_level,
  output logic                 out_new_reading,
  output logic [DIST_W-1:0]    out_distance_mm,
  output logic [DIST_W-1:0]    out_median_mm,
  output logic                 out_timed_out,
  output logic                 out_busy_res
);

  logic [INTERVAL_W-1:0] interval_r;
  logic [SPEED_W-1:0]    speed_r;
  logic [TIMEOUT_W-1:0]  timeout_r;
  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_empty;
  tick_word_t            q_in_word;
  tick_word_t            q_out_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RST;
      speed_r    <= SPEED_RST;
      timeout_r  <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INTERVAL: interval_r <= cfg_data[INTERVAL_W-1:0];
        CFG_SPEED:    speed_r    <= cfg_data[SPEED_W-1:0];
        CFG_TIMEOUT:  timeout_r  <= cfg_data[TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  urm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_echo_level (in_echo_level),
    .interval_i    (interval_r),
    .timeout_i     (timeout_r),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_word_o      (q_in_word)
  );

  urm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .word_i  (q_in_word),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .word_o  (q_out_word)
  );

  urm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .speed_i           (speed_r),
    .q_empty_i         (q_empty),
    .q_word_i          (q_out_word),
    .q_pop_o           (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_trigger_level (out_trigger_level),
    .out_new_reading   (out_new_reading),
    .out_distance_mm   (out_distance_mm),
    .out_median_mm     (out_median_mm),
    .out_timed_out     (out_timed_out),
    .out_busy_res      (out_busy_res)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import urm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [INTERVAL_W-1:0] SINCE_SAT = '1;
  localparam int PULSE_LOW  = 4;
  localparam int PULSE_HIGH = 10;
  localparam int MM_DIV     = 2000;
  localparam int DIST_SAT   = 65535;
  localparam int SETTLE     = 60;

  typedef struct {
    logic              trigger;
    logic              done;
    logic [DIST_W-1:0] dist_mm;
    logic [DIST_W-1:0] median;
    logic              tmo;
    logic              busy;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_echo_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_trigger_level;
  logic out_new_reading;
  logic [DIST_W-1:0] out_distance_mm;
  logic [DIST_W-1:0] out_median_mm;
  logic out_timed_out;
  logic out_busy_res;

  ultrasonic_ranging_median_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_echo_level(in_echo_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_trigger_level(out_trigger_level),
    .out_new_reading(out_new_reading),
    .out_distance_mm(out_distance_mm),
    .out_median_mm(out_median_mm),
    .out_timed_out(out_timed_out),
    .out_busy_res(out_busy_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ranging predictor state
  logic [INTERVAL_W-1:0] cfg_interval;
  logic [SPEED_W-1:0]    cfg_speed;
  logic [TIMEOUT_W-1:0]  cfg_timeout;
  phase_t                rng_phase;
  logic [INTERVAL_W-1:0] since_start;
  logic [TIMEOUT_W-1:0]  wait_cnt;
  logic [TIMEOUT_W-1:0]  echo_cnt;
  logic [DIST_W-1:0]     hist [HIST_DEPTH];
  int                    hist_cnt;
  logic [DIST_W-1:0]     med;
  logic [DIST_W-1:0]     last_dist;
  logic                  trig;

  logic         echo_queue [$];
  tick_result_t reading_queue [$];

  // echo plan for the current measurement
  int plan_gap = 0;
  int plan_high = 0;
  bit plan_jitter = 1'b0;

  bit idling_on = 1'b1;
  int send_gap = 0;
  int recv_gap = 0;
  int n_errors = 0;
  int n_ticks = 0;
  int n_readings = 0;
  int n_timeouts = 0;
  int n_settings = 0;

  function automatic logic [DIST_W-1:0] middle_of_history();
    logic [DIST_W-1:0] s [HIST_DEPTH];
    logic [DIST_W-1:0] v;
    int i, j;
    if (hist_cnt == 0) return '0;
    for (i = 0; i < hist_cnt; i++) s[i] = hist[i];
    for (i = 1; i < hist_cnt; i++) begin
      v = s[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    if (hist_cnt % 2 == 0) return DIST_W'((int'(s[hist_cnt/2-1]) + int'(s[hist_cnt/2])) / 2);
    return s[hist_cnt/2];
  endfunction

  function automatic tick_result_t ranging_tick(input logic echo);
    tick_result_t r;
    logic started;
    int unsigned d;
    int i;
    started = 1'b0;
    r.done = 1'b0;
    r.tmo = 1'b0;
    case (rng_phase)
      PH_TRIG_LOW: begin
        if (wait_cnt >= PULSE_LOW) begin
          trig = 1'b1;
          wait_cnt = '0;
          rng_phase = PH_TRIG_HIGH;
        end else wait_cnt++;
      end
      PH_TRIG_HIGH: begin
        if (wait_cnt >= PULSE_HIGH) begin
          trig = 1'b0;
          wait_cnt = '0;
          rng_phase = PH_WAIT_ECHO;
        end else wait_cnt++;
      end
      PH_WAIT_ECHO: begin
        if (wait_cnt >= cfg_timeout) begin
          r.tmo = 1'b1;
          rng_phase = PH_IDLE;
        end else begin
          wait_cnt++;
          if (echo) begin
            echo_cnt = '0;
            wait_cnt = '0;
            rng_phase = PH_MEASURE;
          end
        end
      end
      PH_MEASURE: begin
        if (echo_cnt >= cfg_timeout) begin
          r.tmo = 1'b1;
          rng_phase = PH_IDLE;
        end else begin
          echo_cnt++;
          if (!echo) begin
            d = (32'(cfg_speed) * 32'(echo_cnt)) / MM_DIV;
            if (d > DIST_SAT) d = DIST_SAT;
            last_dist = d[DIST_W-1:0];
            for (i = HIST_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
            hist[0] = d[DIST_W-1:0];
            if (hist_cnt < HIST_DEPTH) hist_cnt++;
            med = middle_of_history();
            r.done = 1'b1;
            rng_phase = PH_IDLE;
          end
        end
      end
      default: begin
        rng_phase = PH_IDLE;
        if (since_start >= cfg_interval) begin
          trig = 1'b0;
          since_start = '0;
          wait_cnt = '0;
          rng_phase = PH_TRIG_LOW;
          started = 1'b1;
        end
      end
    endcase
    if (!started && since_start != SINCE_SAT) since_start++;
    r.trigger = trig;
    r.dist_mm = last_dist;
    r.median = med;
    r.busy = (rng_phase != PH_IDLE);
    return r;
  endfunction

  task automatic push_tick(input logic echo);
    tick_result_t r;
    r = ranging_tick(echo);
    echo_queue.push_back(echo);
    reading_queue.push_back(r);
    n_ticks++;
    if (r.done) n_readings++;
    if (r.tmo) n_timeouts++;
  endtask

  // mostly well-formed echoes shaped by the current phase, some jittery ones
  task automatic feed_ticks(input int count, input int gap_cap, input int len_cap);
    logic echo;
    repeat (count) begin
      case (rng_phase)
        PH_WAIT_ECHO: begin
          if (plan_jitter) echo = 1'($urandom_range(0, 1));
          else if (plan_gap > 0) begin
            echo = 1'b0;
            plan_gap--;
          end else echo = 1'b1;
        end
        PH_MEASURE: begin
          if (plan_jitter) echo = 1'($urandom_range(0, 1));
          else if (plan_high > 0) begin
            echo = 1'b1;
            plan_high--;
          end else echo = 1'b0;
        end
        default: begin
          echo = ($urandom_range(0, 7) == 0);
          plan_jitter = ($urandom_range(0, 7) == 0);
          plan_gap = $urandom_range(0, gap_cap);
          plan_high = $urandom_range(0, len_cap);
        end
      endcase
      push_tick(echo);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INTERVAL: cfg_interval = data[INTERVAL_W-1:0];
      CFG_SPEED:    cfg_speed = data[SPEED_W-1:0];
      CFG_TIMEOUT:  cfg_timeout = data[TIMEOUT_W-1:0];
      default: ;
    endcase
  endtask

  // unused upper data bits carry noise
  task automatic set_regs(input logic [INTERVAL_W-1:0] interval, input logic [SPEED_W-1:0] speed,
                          input logic [TIMEOUT_W-1:0] tmo);
    write_reg(CFG_INTERVAL, interval);
    write_reg(CFG_SPEED, {(CFG_W - SPEED_W)'($urandom), speed});
    write_reg(CFG_TIMEOUT, {(CFG_W - TIMEOUT_W)'($urandom), tmo});
    if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, CFG_W'($urandom));
    n_settings++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (echo_queue.size() != 0 || in_valid || reading_queue.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string field, input logic [31:0] want, input logic [31:0] seen);
    $display("%0t: %s expected %0d actual %0d", $time, field, want, seen);
    n_errors++;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (echo_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b1;
        in_echo_level <= echo_queue.pop_front();
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reading_queue.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual trigger %0d busy %0d",
                   $time, out_trigger_level, out_busy_res);
          n_errors++;
        end else begin
          want = reading_queue.pop_front();
          if (out_trigger_level !== want.trigger)
            flag_mismatch("trigger_level", 32'(want.trigger), 32'(out_trigger_level));
          if (out_new_reading !== want.done)
            flag_mismatch("new_reading", 32'(want.done), 32'(out_new_reading));
          if (out_distance_mm !== want.dist_mm)
            flag_mismatch("distance_mm", 32'(want.dist_mm), 32'(out_distance_mm));
          if (out_median_mm !== want.median)
            flag_mismatch("median_mm", 32'(want.median), 32'(out_median_mm));
          if (out_timed_out !== want.tmo)
            flag_mismatch("timed_out", 32'(want.tmo), 32'(out_timed_out));
          if (out_busy_res !== want.busy)
            flag_mismatch("busy_res", 32'(want.busy), 32'(out_busy_res));
        end
      end
      if (recv_gap > 0) begin
        out_stall <= 1'b1;
        recv_gap <= recv_gap - 1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        recv_gap <= $urandom_range(0, 3);
      end else out_stall <= 1'b0;
    end
  end

  initial begin
    int p, budget, gap_cap, len_cap, k;
    cfg_interval = INTERVAL_RST;
    cfg_speed = SPEED_RST;
    cfg_timeout = TIMEOUT_RST;
    rng_phase = PH_IDLE;
    since_start = '0;
    wait_cnt = '0;
    echo_cnt = '0;
    for (k = 0; k < HIST_DEPTH; k++) hist[k] = '0;
    hist_cnt = 0;
    med = '0;
    last_dist = '0;
    trig = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // immediate start, zero echo timeout: the wait expires even with echo high
    set_regs('0, '1, '0);
    for (k = 0; k < 20; k++) push_tick(k >= 2);
    wait_drained();

    for (p = 0; p < 14; p++) begin
      idling_on = (p == 13) ? 1'b0 : ($urandom_range(0, 3) != 0);
      budget = 85;
      case (p)
        0: begin
          // saturated interval starts no measurement within this short budget
          set_regs('1, SPEED_W'($urandom), TIMEOUT_W'($urandom));
          budget = 40;
        end
        1: begin
          set_regs('0, '1, '1);
          budget = 800;
        end
        2: set_regs(INTERVAL_W'($urandom_range(0, 12)), '0, TIMEOUT_W'($urandom_range(1, 20)));
        3: set_regs(INTERVAL_W'($urandom_range(0, 12)), SPEED_W'(1), TIMEOUT_W'(1));
        default: set_regs(INTERVAL_W'($urandom_range(0, 24)), SPEED_W'($urandom),
                          TIMEOUT_W'($urandom_range(0, 30)));
      endcase
      if (cfg_timeout > 60) begin
        gap_cap = 30;
        len_cap = 400;
      end else begin
        gap_cap = cfg_timeout + 2;
        len_cap = cfg_timeout + 2;
      end
      feed_ticks(budget, gap_cap, len_cap);
      // the next setting waits until every result word is back
      wait_drained();
    end

    $display("ran %0d echo ticks over %0d register settings", n_ticks, n_settings);
    $display("saw %0d finished readings and %0d echo timeouts", n_readings, n_timeouts);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
